// ----- rtl/hcbp_pkg.sv -----
// Shared types and constants for the code bit packer.
// Used by hcbp_code_table, hcbp_packer and huffman_code_bit_packer; no dependencies.
`default_nettype none

package hcbp_pkg;

    // Item kinds carried on the input tuser field.
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    localparam int BYTE_BITS = 8;
    localparam int PEND_BITS = 7;
    localparam int MODE_W    = 2;

    // Input tdata layout, lowest bit first.
    localparam int SYM_W       = 8;
    localparam int CODE_IN_W   = 32;
    localparam int LEN_IN_W    = 6;
    localparam int SYM_LSB     = 0;
    localparam int CODE_LSB    = SYM_LSB + SYM_W;
    localparam int LEN_LSB     = CODE_LSB + CODE_IN_W;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;

    // Lookup stage item handed to the packer.
    typedef struct packed {
        logic valid;
        logic flush;
    } pk_item_t;

    // Packer status seen by the lookup stage.
    typedef struct packed {
        logic ready;    // no completed byte left to send, can merge a new item
        logic pending;  // leftover bits are held
    } pk_stat_t;

endpackage

`default_nettype wire

// ----- rtl/hcbp_code_table.sv -----
// Code table: one entry per symbol holding the left-aligned code word and its length.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_code_table #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    wr_en,
    input  wire logic [$clog2(SYMBOL_COUNT)-1:0]         wr_idx,
    input  wire logic [hcbp_pkg::CODE_IN_W-1:0]          wr_code_bits,
    input  wire logic [hcbp_pkg::LEN_IN_W-1:0]           wr_code_length,
    input  wire logic                                    rd_en,
    input  wire logic [$clog2(SYMBOL_COUNT)-1:0]         rd_idx,
    output logic [MAX_CODE_LEN-1:0]                      rd_code,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]            rd_len
);
    import hcbp_pkg::*;

    localparam int CW    = MAX_CODE_LEN;
    localparam int LW    = $clog2(MAX_CODE_LEN + 1);
    localparam int EXT_W = (CW > CODE_IN_W) ? CW : CODE_IN_W;
    localparam int ENT_W = CW + LW;

    logic [ENT_W-1:0]        mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic [ENT_W-1:0]        rd_data_reg;
    logic                    rd_ok_reg;

    logic [LW-1:0]    len_clamp;
    logic [LW-1:0]    align_sh;
    logic [EXT_W-1:0] code_masked;
    logic [EXT_W-1:0] code_aligned;

    // Clamp the length, keep only the used bits and move them to the top of the entry.
    always_comb begin
        if (wr_code_length > LEN_IN_W'(MAX_CODE_LEN)) begin
            len_clamp = LW'(MAX_CODE_LEN);
        end else begin
            len_clamp = LW'(wr_code_length);
        end
        align_sh     = LW'(MAX_CODE_LEN) - len_clamp;
        code_masked  = EXT_W'(wr_code_bits) & ~({EXT_W{1'b1}} << len_clamp);
        code_aligned = code_masked << align_sh;
    end

    // Table storage with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {len_clamp, code_aligned[CW-1:0]};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Entries not yet loaded read as a zero-length code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_code = rd_ok_reg ? rd_data_reg[CW-1:0] : '0;
    assign rd_len  = rd_ok_reg ? rd_data_reg[ENT_W-1:CW] : '0;

endmodule

`default_nettype wire

// ----- rtl/hcbp_packer.sv -----
// Bit packer: merges a looked-up code into the leftover bits and sends one byte per beat.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire hcbp_pkg::pk_item_t                   item,
    input  wire logic [MAX_CODE_LEN-1:0]              code_la,
    input  wire logic [$clog2(MAX_CODE_LEN+1)-1:0]    code_len,
    output hcbp_pkg::pk_stat_t                        stat,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0]            out_byte,
    output logic                                      out_last
);
    import hcbp_pkg::*;

    localparam int CW    = MAX_CODE_LEN;
    localparam int AW    = CW + PEND_BITS;
    localparam int CNT_W = $clog2(AW + 1);

    // Ones over the top byte of the bit word.
    localparam logic [AW-1:0] TOP_MASK = {{BYTE_BITS{1'b1}}, {(AW - BYTE_BITS){1'b0}}};

    // Bit word is left aligned: the earliest unsent bit is the top bit.
    logic [AW-1:0]    word_reg, word_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0] out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             draining;
    logic             take;
    logic             out_free;
    logic             emit;
    logic [2:0]       pend_cnt;
    logic [AW-1:0]    src_word;
    logic [CNT_W-1:0] src_count;

    assign draining = count_reg >= CNT_W'(BYTE_BITS);
    assign pend_cnt = count_reg[2:0];
    assign take     = item.valid && !draining;
    assign out_free = !out_valid_reg || out_ready;

    // Pick the word to work on: the one still draining, or leftover bits merged with the item.
    // Flush padding fills only the rest of the top byte, so nothing is left below it.
    always_comb begin
        src_word  = word_reg;
        src_count = count_reg;
        if (take) begin
            if (item.flush) begin
                if (pend_cnt != 3'd0) begin
                    src_word  = word_reg | ((TOP_MASK >> pend_cnt) & TOP_MASK);
                    src_count = CNT_W'(BYTE_BITS);
                end
            end else begin
                src_word  = word_reg | ({code_la, {PEND_BITS{1'b0}}} >> pend_cnt);
                src_count = count_reg + CNT_W'(code_len);
            end
        end
    end

    // Send the top byte whenever one is complete and the output register is free.
    always_comb begin
        emit           = (src_count >= CNT_W'(BYTE_BITS)) && out_free;
        word_next      = src_word;
        count_next     = src_count;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            word_next      = src_word << BYTE_BITS;
            count_next     = src_count - CNT_W'(BYTE_BITS);
            out_valid_next = 1'b1;
            out_byte_next  = src_word[AW-1 -: BYTE_BITS];
            out_last_next  = src_count < CNT_W'(2 * BYTE_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            word_reg      <= word_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign stat.ready   = !draining;
    assign stat.pending = count_reg != '0;
    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/huffman_code_bit_packer.sv -----
// Top level of the table-driven variable-length code packer.
// Depends on hcbp_pkg, hcbp_code_table and hcbp_packer.
`default_nettype none

// Takes one input beat per cycle unless stalled by the packer. A load beat writes a code
// table entry at once and gives no output. An encode or flush beat passes a lookup stage
// (the registered table read) and then the packer, which merges the code into the
// leftover bits and sends one byte per cycle, as m_tready allows, through an output
// register; the first byte passes the lookup register and then the output register
// before it is offered. An item that completes more than one byte holds the next item in
// the lookup stage until its bytes are sent (up to (MAX_CODE_LEN + 7) / 8 bytes per
// item); items that complete at most one byte flow at one per cycle while the output is
// taken. The table is read as all zero-length codes after reset, with no clearing pass.
// m_tlast marks the last byte caused by one input item.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: symbol [7:0], code_bits [39:8], code_length [45:40], zero [47:46]
    input  wire logic [hcbp_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: mode [1:0]
    input  wire logic [hcbp_pkg::MODE_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: out_byte [7:0]
    output logic [hcbp_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);
    import hcbp_pkg::*;

    localparam int IW = $clog2(SYMBOL_COUNT);
    localparam int CW = MAX_CODE_LEN;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    logic            s_beat;
    logic [SYM_W-1:0] symbol;
    logic            in_range;
    logic            is_load, is_encode, is_flush;
    logic            a_valid_reg, a_valid_next;
    logic            a_flush_reg, a_flush_next;
    logic [CW-1:0]   rd_code;
    logic [LW-1:0]   rd_len;
    pk_item_t        a_item;
    pk_stat_t        pk_stat;

    // Decode the item kind of an input beat.
    always_comb begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        case (mode_t'(s_tuser))
            MODE_LOAD:   is_load   = 1'b1;
            MODE_ENCODE: is_encode = 1'b1;
            MODE_FLUSH:  is_flush  = 1'b1;
            default:     ;
        endcase
    end

    assign symbol   = s_tdata[SYM_LSB +: SYM_W];
    assign in_range = {1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign s_tready = !a_valid_reg || pk_stat.ready;
    assign s_beat   = s_tvalid && s_tready;

    hcbp_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr_en          (s_beat && is_load && in_range),
        .wr_idx         (symbol[IW-1:0]),
        .wr_code_bits   (s_tdata[CODE_LSB +: CODE_IN_W]),
        .wr_code_length (s_tdata[LEN_LSB +: LEN_IN_W]),
        .rd_en          (s_beat && is_encode && in_range),
        .rd_idx         (symbol[IW-1:0]),
        .rd_code        (rd_code),
        .rd_len         (rd_len)
    );

    // Lookup stage: holds an encode or flush item until the packer takes it.
    // An encode of a symbol beyond the table reads as a zero-length code.
    always_comb begin
        a_valid_next = a_valid_reg && !pk_stat.ready;
        a_flush_next = a_flush_reg;
        if (s_beat && (is_encode || is_flush)) begin
            a_valid_next = 1'b1;
            a_flush_next = is_flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_flush_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            a_flush_reg <= a_flush_next;
        end
    end

    logic [CW-1:0] a_code;
    logic [LW-1:0] a_len;

    // A missed lookup for a symbol beyond the table leaves stale read data, so mask it.
    logic a_hit_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_hit_reg <= 1'b0;
        end else if (s_beat && is_encode) begin
            a_hit_reg <= in_range;
        end
    end

    assign a_code       = a_hit_reg ? rd_code : '0;
    assign a_len        = a_hit_reg ? rd_len : '0;
    assign a_item.valid = a_valid_reg;
    assign a_item.flush = a_flush_reg;

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (a_item),
        .code_la   (a_code),
        .code_len  (a_len),
        .stat      (pk_stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef ASSERT_OFF
    // While completed bytes remain in the packer, a byte is on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !pk_stat.ready |-> m_tvalid)
        else $error("packer holds a complete byte with no output beat offered");

    // A byte taken without last is followed at once by the next byte of the same item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("item bytes interrupted after a non-last beat");

    // An item waiting for the packer is not dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !pk_stat.ready) |=> a_valid_reg)
        else $error("lookup stage item lost while packer busy");

    // A flush taken with a free output leaves no bits behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && a_flush_reg && pk_stat.ready && (!m_tvalid || m_tready))
        |=> !pk_stat.pending)
        else $error("leftover bits remain after flush");
`endif

endmodule

`default_nettype wire
